// ===== src/aar_pkg.sv =====
// Shared types, widths and constants for the axis-angle rotation matrix block.
// Holds the CORDIC arctangent table and the output saturation helper.
// No dependencies.
package aar_pkg;

    localparam int FRAC_BITS     = 14;
    localparam int CORDIC_STAGES = 16;

    localparam int AX_W   = 16;   // axis component width
    localparam int OUT_W  = 16;   // matrix entry width
    localparam int ANG_W  = 17;   // angle in 1/64 degree, one bit of headroom
    localparam int Z_W    = 27;   // residual angle, 1/65536 degree
    localparam int XY_W   = 33;   // CORDIC x and y, Q30
    localparam int STG_W  = 5;    // stage index, up to 32 stages
    localparam int P_W    = 2 * AX_W;           // axis product
    localparam int OMC_W  = XY_W + 1;           // one minus cosine
    localparam int SPLIT  = 16;                 // low slice of one minus cosine
    localparam int PH_W   = P_W + OMC_W - SPLIT;
    localparam int PL_W   = P_W + SPLIT + 1;
    localparam int S_W    = AX_W + XY_W;        // axis times sine
    localparam int ACC_W  = 64;
    localparam int RND_SHIFT = 30;
    localparam int NUM_M  = 9;
    localparam int Z_SHIFT = 10;                // 1/64 degree to 1/65536 degree

    localparam logic signed [ANG_W-1:0] FULL_TURN    = 17'sd23040;
    localparam logic signed [ANG_W-1:0] HALF_TURN    = 17'sd11520;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 17'sd5760;

    localparam logic signed [XY_W-1:0]  GAIN_Q30 = 33'sd652032874;
    localparam logic signed [OMC_W-1:0] ONE_Q30  = OMC_W'(1) <<< RND_SHIFT;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (RND_SHIFT - 1);

    localparam logic signed [ACC_W-RND_SHIFT-1:0] OUT_MAX = (ACC_W-RND_SHIFT)'(32767);
    localparam logic signed [ACC_W-RND_SHIFT-1:0] OUT_MIN = -(ACC_W-RND_SHIFT)'(32768);

    typedef struct packed {
        logic signed [AX_W-1:0] axis_x;
        logic signed [AX_W-1:0] axis_y;
        logic signed [AX_W-1:0] axis_z;
        logic signed [AX_W-1:0] angle_deg;
    } t_axis_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] m00;
        logic signed [OUT_W-1:0] m01;
        logic signed [OUT_W-1:0] m02;
        logic signed [OUT_W-1:0] m10;
        logic signed [OUT_W-1:0] m11;
        logic signed [OUT_W-1:0] m12;
        logic signed [OUT_W-1:0] m20;
        logic signed [OUT_W-1:0] m21;
        logic signed [OUT_W-1:0] m22;
    } t_matrix;

    // Word handed from cell to cell along the CORDIC chain
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   flip;
        logic signed [AX_W-1:0] ax;
        logic signed [AX_W-1:0] ay;
        logic signed [AX_W-1:0] az;
    } t_cordic;

    typedef logic signed [ACC_W-1:0] t_acc;

    // atan(2^-i) in 1/65536 degree; zero past stage 22
    function automatic logic signed [Z_W-1:0] atan_of(input logic [STG_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 27'sd2949120;
            5'd1:    v = 27'sd1740967;
            5'd2:    v = 27'sd919879;
            5'd3:    v = 27'sd466945;
            5'd4:    v = 27'sd234379;
            5'd5:    v = 27'sd117304;
            5'd6:    v = 27'sd58666;
            5'd7:    v = 27'sd29335;
            5'd8:    v = 27'sd14668;
            5'd9:    v = 27'sd7334;
            5'd10:   v = 27'sd3667;
            5'd11:   v = 27'sd1833;
            5'd12:   v = 27'sd917;
            5'd13:   v = 27'sd458;
            5'd14:   v = 27'sd229;
            5'd15:   v = 27'sd115;
            5'd16:   v = 27'sd57;
            5'd17:   v = 27'sd29;
            5'd18:   v = 27'sd14;
            5'd19:   v = 27'sd7;
            5'd20:   v = 27'sd4;
            5'd21:   v = 27'sd2;
            5'd22:   v = 27'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Drop the Q30 fraction (floor) and clamp to the 16-bit range
    function automatic logic signed [OUT_W-1:0] sat_out(input t_acc acc);
        logic signed [ACC_W-RND_SHIFT-1:0] v;
        logic signed [OUT_W-1:0]           r;
        v = (ACC_W-RND_SHIFT)'(acc >>> RND_SHIFT);
        if (v > OUT_MAX) begin
            r = OUT_MAX[OUT_W-1:0];
        end else if (v < OUT_MIN) begin
            r = OUT_MIN[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/aar_cordic_cell.sv =====
// One CORDIC rotation step in degrees, registered; cells chain into the sin/cos unit.
// Depends on aar_pkg (t_cordic, atan_of).
module aar_cordic_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [aar_pkg::STG_W-1:0]     i_stage,
    input  logic                          i_valid,
    input  aar_pkg::t_cordic              i_data,
    output logic                          o_valid,
    output aar_pkg::t_cordic              o_data
);
    import aar_pkg::*;

    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  da;
    t_cordic                n_data;
    t_cordic                r_data;
    logic                   r_valid;

    always_comb begin
        dx     = i_data.y >>> i_stage;
        dy     = i_data.x >>> i_stage;
        da     = atan_of(i_stage);
        n_data = i_data;
        // rotate toward zero residual angle
        if (!i_data.z[Z_W-1]) begin
            n_data.x = i_data.x - dx;
            n_data.y = i_data.y + dy;
            n_data.z = i_data.z - da;
        end else begin
            n_data.x = i_data.x + dx;
            n_data.y = i_data.y - dy;
            n_data.z = i_data.z + da;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== src/aar_rodrigues.sv =====
// Multiply-accumulate pipeline that forms the nine Rodrigues terms from cos, sin and the axis.
// Depends on aar_pkg (t_cordic, t_acc, widths).
module aar_rodrigues (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  aar_pkg::t_cordic  i_data,
    output logic              o_valid,
    output aar_pkg::t_acc     o_acc [aar_pkg::NUM_M]
);
    import aar_pkg::*;

    localparam int NUM_P = 6;
    localparam int NUM_V = 5;
    localparam int XX = 0;
    localparam int YY = 1;
    localparam int ZZ = 2;
    localparam int XY = 3;
    localparam int XZ = 4;
    localparam int YZ = 5;

    logic [NUM_V-1:0] r_v;

    // first stage: undo the half-turn fold, axis products
    logic signed [XY_W-1:0]  r1_c;
    logic signed [XY_W-1:0]  r1_s;
    logic signed [AX_W-1:0]  r1_ax;
    logic signed [AX_W-1:0]  r1_ay;
    logic signed [AX_W-1:0]  r1_az;
    logic signed [P_W-1:0]   r1_p [NUM_P];

    // second stage: one minus cosine, cosine term, sine terms
    logic signed [OMC_W-1:0] r2_omc;
    t_acc                    r2_cf;
    logic signed [S_W-1:0]   r2_xs;
    logic signed [S_W-1:0]   r2_ys;
    logic signed [S_W-1:0]   r2_zs;
    logic signed [P_W-1:0]   r2_p [NUM_P];

    // third stage: partial products of axis product times one minus cosine
    logic signed [PH_W-1:0]  r3_ph [NUM_P];
    logic signed [PL_W-1:0]  r3_pl [NUM_P];
    t_acc                    r3_cf;
    logic signed [S_W-1:0]   r3_xs;
    logic signed [S_W-1:0]   r3_ys;
    logic signed [S_W-1:0]   r3_zs;

    // fourth stage: recombined and floored terms
    t_acc                    r4_t [NUM_P];
    t_acc                    r4_cf;
    t_acc                    r4_xs;
    t_acc                    r4_ys;
    t_acc                    r4_zs;

    t_acc                    r5_acc [NUM_M];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NUM_V-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_c  <= i_data.flip ? -i_data.x : i_data.x;
            r1_s  <= i_data.flip ? -i_data.y : i_data.y;
            r1_ax <= i_data.ax;
            r1_ay <= i_data.ay;
            r1_az <= i_data.az;
            r1_p[XX] <= P_W'(i_data.ax) * P_W'(i_data.ax);
            r1_p[YY] <= P_W'(i_data.ay) * P_W'(i_data.ay);
            r1_p[ZZ] <= P_W'(i_data.az) * P_W'(i_data.az);
            r1_p[XY] <= P_W'(i_data.ax) * P_W'(i_data.ay);
            r1_p[XZ] <= P_W'(i_data.ax) * P_W'(i_data.az);
            r1_p[YZ] <= P_W'(i_data.ay) * P_W'(i_data.az);

            r2_omc <= ONE_Q30 - OMC_W'(r1_c);
            r2_cf  <= ACC_W'(r1_c) <<< FRAC_BITS;
            r2_xs  <= S_W'(r1_ax) * S_W'(r1_s);
            r2_ys  <= S_W'(r1_ay) * S_W'(r1_s);
            r2_zs  <= S_W'(r1_az) * S_W'(r1_s);
            r2_p   <= r1_p;

            for (int k = 0; k < NUM_P; k++) begin
                r3_ph[k] <= PH_W'(r2_p[k]) * PH_W'($signed(r2_omc[OMC_W-1:SPLIT]));
                r3_pl[k] <= PL_W'(r2_p[k]) * PL_W'($signed({1'b0, r2_omc[SPLIT-1:0]}));
            end
            r3_cf <= r2_cf;
            r3_xs <= r2_xs;
            r3_ys <= r2_ys;
            r3_zs <= r2_zs;

            for (int k = 0; k < NUM_P; k++) begin
                r4_t[k] <= ((ACC_W'(r3_ph[k]) <<< SPLIT) + ACC_W'(r3_pl[k])) >>> FRAC_BITS;
            end
            r4_cf <= r3_cf;
            r4_xs <= ACC_W'(r3_xs);
            r4_ys <= ACC_W'(r3_ys);
            r4_zs <= ACC_W'(r3_zs);

            // add the rounding half here so the output stage only shifts and clamps
            r5_acc[0] <= r4_t[XX] + r4_cf + RND_HALF;
            r5_acc[1] <= r4_t[XY] - r4_zs + RND_HALF;
            r5_acc[2] <= r4_t[XZ] + r4_ys + RND_HALF;
            r5_acc[3] <= r4_t[XY] + r4_zs + RND_HALF;
            r5_acc[4] <= r4_t[YY] + r4_cf + RND_HALF;
            r5_acc[5] <= r4_t[YZ] - r4_xs + RND_HALF;
            r5_acc[6] <= r4_t[XZ] - r4_ys + RND_HALF;
            r5_acc[7] <= r4_t[YZ] + r4_xs + RND_HALF;
            r5_acc[8] <= r4_t[ZZ] + r4_cf + RND_HALF;
        end
    end

    assign o_valid = r_v[NUM_V-1];
    assign o_acc   = r5_acc;

endmodule

// ===== src/axis_angle_rotation_matrix.sv =====
// Top level of the axis-angle to rotation matrix block: angle reduction, CORDIC chain,
// Rodrigues pipeline and saturating output register. Depends on aar_pkg,
// aar_cordic_cell and aar_rodrigues.
//
// Takes one beat per cycle while o_stall is low (axis in Q1.14, angle in 1/64 degree)
// and returns the 3x3 rotation matrix, row-major, in saturated Q1.14. Throughput is one
// beat per clock when the output is not stalled. The path is one reduction register,
// one CORDIC cell per stage, five multiply-accumulate registers and one output register. The
// whole pipeline holds while a finished beat waits at the output under stall, so
// o_stall follows i_stall whenever o_valid is high.
module axis_angle_rotation_matrix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  aar_pkg::t_axis_in  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output aar_pkg::t_matrix   o_data
);
    import aar_pkg::*;

    localparam logic signed [Z_W-1:0] Z_RES = Z_W'(1) <<< 17;

    logic                   en;
    logic signed [ANG_W-1:0] ang;
    logic signed [ANG_W-1:0] ang_w;
    logic signed [ANG_W-1:0] ang_q;
    logic                    flip;
    t_cordic                 n_front;

    logic                    w_valid [CORDIC_STAGES+1];
    t_cordic                 w_data  [CORDIC_STAGES+1];

    logic                    rod_valid;
    t_acc                    rod_acc [NUM_M];

    logic                    r_front_valid;
    t_cordic                 r_front;
    logic                    r_out_valid;
    t_matrix                 r_out;

    assign o_stall = r_out_valid && i_stall;
    assign en      = !o_stall;

    // wrap into one turn around zero, then fold into a quarter turn
    always_comb begin
        ang = ANG_W'(i_data.angle_deg);
        if (ang >= HALF_TURN) begin
            ang_w = ang - FULL_TURN;
        end else if (ang < -HALF_TURN) begin
            ang_w = ang + FULL_TURN;
        end else begin
            ang_w = ang;
        end
        if (ang_w > QUARTER_TURN) begin
            ang_q = ang_w - HALF_TURN;
            flip  = 1'b1;
        end else if (ang_w < -QUARTER_TURN) begin
            ang_q = ang_w + HALF_TURN;
            flip  = 1'b1;
        end else begin
            ang_q = ang_w;
            flip  = 1'b0;
        end
        n_front.x    = GAIN_Q30;
        n_front.y    = '0;
        n_front.z    = {ang_q, {Z_SHIFT{1'b0}}};
        n_front.flip = flip;
        n_front.ax   = i_data.axis_x;
        n_front.ay   = i_data.axis_y;
        n_front.az   = i_data.axis_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_valid <= 1'b0;
        end else if (en) begin
            r_front_valid <= i_valid;
        end
        if (en) begin
            r_front <= n_front;
        end
    end

    assign w_valid[0] = r_front_valid;
    assign w_data[0]  = r_front;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        aar_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (STG_W'(k)),
            .i_valid (w_valid[k]),
            .i_data  (w_data[k]),
            .o_valid (w_valid[k+1]),
            .o_data  (w_data[k+1])
        );
    end

    aar_rodrigues u_rod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_valid[CORDIC_STAGES]),
        .i_data  (w_data[CORDIC_STAGES]),
        .o_valid (rod_valid),
        .o_acc   (rod_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= rod_valid;
        end
        if (en) begin
            r_out.m00 <= sat_out(rod_acc[0]);
            r_out.m01 <= sat_out(rod_acc[1]);
            r_out.m02 <= sat_out(rod_acc[2]);
            r_out.m10 <= sat_out(rod_acc[3]);
            r_out.m11 <= sat_out(rod_acc[4]);
            r_out.m12 <= sat_out(rod_acc[5]);
            r_out.m20 <= sat_out(rod_acc[6]);
            r_out.m21 <= sat_out(rod_acc[7]);
            r_out.m22 <= sat_out(rod_acc[8]);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // a held output freezes the front of the chain as well
    a_front_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_front_valid))
        else $error("front register moved while the output was stalled");

    // an unstalled output takes the beat leaving the multiply pipeline
    a_out_follow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |=> (o_valid == $past(rod_valid)))
        else $error("output valid lost or invented a beat");

    // CORDIC must have driven the residual angle close to zero
    a_cordic_conv : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[CORDIC_STAGES] |->
            (w_data[CORDIC_STAGES].z < Z_RES) && (w_data[CORDIC_STAGES].z > -Z_RES))
        else $error("CORDIC residual angle did not converge");

endmodule

// ===== bench/axis_angle_rotation_matrix_tb.sv =====
`timescale 1ns / 1ps
// Testbench for axis_angle_rotation_matrix: drives axis/angle beats and
// checks every returned matrix against a bit-exact CORDIC + Rodrigues predictor.
// Depends on aar_pkg and the RTL under src/.
module axis_angle_rotation_matrix_tb;
    import aar_pkg::*;

    localparam int LATENCY     = CORDIC_STAGES + 7;
    localparam int RAND_ITEMS  = 1750;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 8;
    localparam int QUIET_FIRST = 700;
    localparam int QUIET_LAST  = 1000;

    localparam longint ANG_FULL    = 23040;
    localparam longint ANG_HALF    = 11520;
    localparam longint ANG_QUARTER = 5760;
    localparam longint Q30_ONE     = longint'(1) << 30;
    localparam longint Q30_GAIN    = 652032874;

    class rotation_scoreboard;
        t_matrix     matrix_q[$];
        int unsigned beats_in;
        int unsigned beats_out;
        int unsigned field_errors;
        int unsigned stray_results;
        int unsigned reports;

        function new();
            beats_in      = 0;
            beats_out     = 0;
            field_errors  = 0;
            stray_results = 0;
            reports       = 0;
        endfunction

        // atan(2^-i) in 1/65536 degree, rounded
        function longint atan_step(input int i);
            case (i)
                0:  return 2949120;
                1:  return 1740967;
                2:  return 919879;
                3:  return 466945;
                4:  return 234379;
                5:  return 117304;
                6:  return 58666;
                7:  return 29335;
                8:  return 14668;
                9:  return 7334;
                10: return 3667;
                11: return 1833;
                12: return 917;
                13: return 458;
                14: return 229;
                15: return 115;
                16: return 57;
                17: return 29;
                18: return 14;
                19: return 7;
                20: return 4;
                21: return 2;
                22: return 1;
                default: return 0;
            endcase
        endfunction

        // cosine and sine in Q30 for an angle in 1/64 degree
        function void cos_sin(input longint ang, output longint c, output longint s);
            longint r;
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            bit     flip;
            r    = ang % ANG_FULL;
            flip = 1'b0;
            if (r < 0) r += ANG_FULL;
            if (r >= ANG_HALF) r -= ANG_FULL;
            // fold into a quarter turn, negate both afterwards
            if (r > ANG_QUARTER) begin
                r -= ANG_HALF;
                flip = 1'b1;
            end else if (r < -ANG_QUARTER) begin
                r += ANG_HALF;
                flip = 1'b1;
            end
            z = r * 1024;
            x = Q30_GAIN;
            y = 0;
            for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx;
                    y += dy;
                    z -= atan_step(i);
                end else begin
                    x += dx;
                    y -= dy;
                    z += atan_step(i);
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function logic signed [OUT_W-1:0] round_clamp(input longint acc);
            longint v;
            v = (acc + (longint'(1) << 29)) >>> 30;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[OUT_W-1:0];
        endfunction

        function t_matrix rotation_of(input t_axis_in item);
            t_matrix m;
            longint  ax, ay, az, c, s, omc, cf, xs, ys, zs;
            longint  txx, tyy, tzz, txy, txz, tyz;
            ax = longint'(item.axis_x);
            ay = longint'(item.axis_y);
            az = longint'(item.axis_z);
            cos_sin(longint'(item.angle_deg), c, s);
            omc = Q30_ONE - c;
            cf  = c * (longint'(1) << FRAC_BITS);
            xs  = ax * s;
            ys  = ay * s;
            zs  = az * s;
            txx = (ax * ax * omc) >>> FRAC_BITS;
            tyy = (ay * ay * omc) >>> FRAC_BITS;
            tzz = (az * az * omc) >>> FRAC_BITS;
            txy = (ax * ay * omc) >>> FRAC_BITS;
            txz = (ax * az * omc) >>> FRAC_BITS;
            tyz = (ay * az * omc) >>> FRAC_BITS;
            m.m00 = round_clamp(txx + cf);
            m.m01 = round_clamp(txy - zs);
            m.m02 = round_clamp(txz + ys);
            m.m10 = round_clamp(txy + zs);
            m.m11 = round_clamp(tyy + cf);
            m.m12 = round_clamp(tyz - xs);
            m.m20 = round_clamp(txz - ys);
            m.m21 = round_clamp(tyz + xs);
            m.m22 = round_clamp(tzz + cf);
            return m;
        endfunction

        function void note_input(input t_axis_in item);
            matrix_q.push_back(rotation_of(item));
            beats_in++;
        endfunction

        function void check_result(input t_matrix got);
            t_matrix                want;
            logic [NUM_M*OUT_W-1:0] gv;
            logic [NUM_M*OUT_W-1:0] wv;
            logic [OUT_W-1:0]       ge;
            logic [OUT_W-1:0]       we;
            beats_out++;
            if (matrix_q.size() == 0) begin
                stray_results++;
                if (reports < 10) begin
                    reports++;
                    $display("unexpected matrix beat %h at %0t", got, $realtime);
                end
                return;
            end
            want = matrix_q.pop_front();
            gv   = got;
            wv   = want;
            for (int k = 0; k < NUM_M; k++) begin
                ge = gv[(NUM_M-1-k)*OUT_W +: OUT_W];
                we = wv[(NUM_M-1-k)*OUT_W +: OUT_W];
                if (ge !== we) begin
                    field_errors++;
                    if (reports < 10) begin
                        reports++;
                        $display("beat %0d m%0d%0d: expected %0d, got %0d", beats_out - 1,
                                 k / 3, k % 3, $signed(we), $signed(ge));
                    end
                end
            end
        endfunction

        function int unsigned pending();
            return matrix_q.size();
        endfunction
    endclass

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     i_stall = 1'b0;
    t_axis_in i_data  = '0;
    logic     o_stall;
    logic     o_valid;
    t_matrix  o_data;

    bit                 quiet = 1'b0;
    int unsigned        cycle_count = 0;
    rotation_scoreboard sb = new();

    axis_angle_rotation_matrix DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit idle_roll();
        return !quiet && ($urandom_range(99) < IDLE_PCT);
    endfunction

    function automatic t_axis_in make_item(input int ax, input int ay, input int az,
                                           input int ang);
        t_axis_in item;
        item.axis_x    = AX_W'(ax);
        item.axis_y    = AX_W'(ay);
        item.axis_z    = AX_W'(az);
        item.angle_deg = AX_W'(ang);
        return item;
    endfunction

    function automatic int clamp_int(input int v, input int lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic int unit_scaled(input real v, input real n);
        return clamp_int($rtoi(v / n * 16384.0), 16384);
    endfunction

    function automatic int edge_component();
        case ($urandom_range(4))
            0: return -16384;
            1: return 16384;
            2: return 0;
            3: return 1;
            default: return -1;
        endcase
    endfunction

    function automatic int random_angle();
        int k;
        if ($urandom_range(99) < 20) begin
            // land on or next to a multiple of a quarter turn
            k = int'($urandom_range(8)) - 4;
            return clamp_int(k * 5760 + int'($urandom_range(4)) - 2, 23040);
        end
        return int'($urandom_range(46080)) - 23040;
    endfunction

    function automatic t_axis_in random_item();
        real vx, vy, vz, n;
        int  pick;
        pick = $urandom_range(99);
        if (pick < 65) begin
            vx = real'($urandom_range(2000)) - 1000.0;
            vy = real'($urandom_range(2000)) - 1000.0;
            vz = real'($urandom_range(2000)) - 1000.0;
            n  = $sqrt(vx * vx + vy * vy + vz * vz);
            if (n < 1.0) begin
                vx = 1.0;
                n  = 1.0;
            end
            return make_item(unit_scaled(vx, n), unit_scaled(vy, n), unit_scaled(vz, n),
                             random_angle());
        end else if (pick < 85) begin
            return make_item(int'($urandom_range(32768)) - 16384,
                             int'($urandom_range(32768)) - 16384,
                             int'($urandom_range(32768)) - 16384, random_angle());
        end
        return make_item(edge_component(), edge_component(), edge_component(),
                         random_angle());
    endfunction

    // Present one beat and hold it until the block takes it
    task automatic send_beat(input t_axis_in item);
        @(negedge i_clk);
        while (idle_roll()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(item);
    endtask

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            i_stall <= idle_roll();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_data);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("axis_angle_rotation_matrix_tb failed");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Axis and angle corners: unit axes, full and quarter turns, the fold
        // past a quarter turn, zero and oversized axes that saturate
        send_beat(make_item(16384, 0, 0, 0));
        send_beat(make_item(0, 16384, 0, 5760));
        send_beat(make_item(0, 0, 16384, -5760));
        send_beat(make_item(16384, 0, 0, 23040));
        send_beat(make_item(0, 16384, 0, -23040));
        send_beat(make_item(0, 0, 16384, 11520));
        send_beat(make_item(0, 0, -16384, -11520));
        send_beat(make_item(16384, 0, 0, 5761));
        send_beat(make_item(0, -16384, 0, -5761));
        send_beat(make_item(-16384, 0, 0, 11519));
        send_beat(make_item(9459, 9459, 9459, 7680));
        send_beat(make_item(16384, 16384, 16384, 2880));
        send_beat(make_item(-16384, -16384, -16384, -17280));
        send_beat(make_item(0, 0, 0, 1234));
        send_beat(make_item(16384, -16384, 16384, -1));
        send_beat(make_item(11585, -11585, 0, 1));
        send_beat(make_item(0, 11585, 11585, 17281));
        send_beat(make_item(-16384, 16384, -16384, 23039));
        send_beat(make_item(16384, 16384, 0, -23039));
        send_beat(make_item(0, 0, 16384, 2880));
        send_beat(make_item(1, -1, 1, -11521));
        send_beat(make_item(-16384, 0, 16384, 11521));

        for (int n = 0; n < RAND_ITEMS; n++) begin
            quiet = (n >= QUIET_FIRST) && (n < QUIET_LAST);
            send_beat(random_item());
        end
        quiet = 1'b0;
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("Checked %0d of %0d matrices: unit, oversized and zero axes over the",
                 sb.beats_out, sb.beats_in);
        $display("full +/-360 degree range, with quarter-turn folds and idle/stall gaps.");
        if (sb.field_errors == 0 && sb.stray_results == 0 && sb.pending() == 0) begin
            $display("axis_angle_rotation_matrix_tb passed");
        end else begin
            $display("%0d field mismatches, %0d unexpected beats, %0d missing beats",
                     sb.field_errors, sb.stray_results, sb.pending());
            $display("axis_angle_rotation_matrix_tb failed");
        end
        $finish;
    end

endmodule
